### rtl/aafc_pkg.sv
// Shared types and constants of the frustum culling block.
package aafc_pkg;

    // Six planes, each with three Q1.14 normal components and a Q8.8 offset.
    localparam int PLANE_COUNT = 6;
    localparam int COMP_W      = 16;
    localparam int NORMAL_FRAC = 14;
    localparam int AXIS_COUNT  = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int M_TDATA_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_RIGHT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_LEFT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_FAR    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_NEAR   = 3'd5;

    // Item kinds carried in tuser.
    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    // One plane as written through the configuration port, a in the low bits.
    typedef struct packed {
        logic signed [COMP_W-1:0] d;
        logic signed [COMP_W-1:0] c;
        logic signed [COMP_W-1:0] b;
        logic signed [COMP_W-1:0] a;
    } plane_t;

endpackage

### rtl/aafc_cfg_regs.sv
// Plane register file written through the configuration port.
module aafc_cfg_regs
    import aafc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output plane_t                plane [PLANE_COUNT]
);

    plane_t plane_reg [PLANE_COUNT];

    // Writes to indexes past the last plane are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_addr <= REG_PLANE_NEAR))
        begin
            plane_reg[cfg_addr] <= plane_t'(cfg_wdata);
        end
    end

    assign plane = plane_reg;

endmodule

### rtl/aafc_plane_eval.sv
// Test of one item against one plane: corner select, products, sum and sign.
module aafc_plane_eval
    import aafc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic                          kind,
    input  logic signed [COORD_WIDTH-1:0] lo [AXIS_COUNT],
    input  logic signed [COORD_WIDTH-1:0] hi [AXIS_COUNT],
    input  plane_t                        plane,
    output logic                          behind
);

    localparam int PROD_W = COORD_WIDTH + COMP_W;
    localparam int OFS_W  = COMP_W + NORMAL_FRAC;
    localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

    logic signed [COMP_W-1:0]      nrm       [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] sel       [AXIS_COUNT];
    logic signed [PROD_W-1:0]      prod_next [AXIS_COUNT];
    logic signed [PROD_W-1:0]      prod_reg  [AXIS_COUNT];
    logic signed [COMP_W-1:0]      ofs_reg;
    logic signed [SUM_W-1:0]       sum;

    assign nrm[0] = plane.a;
    assign nrm[1] = plane.b;
    assign nrm[2] = plane.c;

    // The corner farthest along the normal is the per-axis coordinate that
    // maximizes its product term, so one corner decides for the whole box.
    always_comb
    begin
        for (int k = 0; k < AXIS_COUNT; k++)
        begin
            if (kind == KIND_POINT)
            begin
                sel[k] = lo[k];
            end
            else if (!nrm[k][COMP_W-1])
            begin
                sel[k] = (hi[k] > lo[k]) ? hi[k] : lo[k];
            end
            else
            begin
                sel[k] = (hi[k] < lo[k]) ? hi[k] : lo[k];
            end
            prod_next[k] = PROD_W'(sel[k]) * PROD_W'(nrm[k]);
        end
    end

    // Product register between the multipliers and the adder.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            ofs_reg  <= plane.d;
        end
    end

    // Exact sum with 22 fraction bits; on or behind means at most zero.
    assign sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
               + (SUM_W'(ofs_reg) <<< NORMAL_FRAC);

    assign behind = sum[SUM_W-1] || (sum == '0);

endmodule

### rtl/aabb_frustum_cull.sv
// Top level of the box and point frustum culling block.
//
// Each item is a box (min and max corners) or a point tested against six
// planes held in configuration registers; one result item with an inside flag
// comes back for every input item, in order. The block takes one item per
// clock cycle while the output is not stalled and passes it through three
// registers: an input register, a product register behind the per-plane
// multipliers and the result register. Each stage frees itself as soon as the
// next stage can take its item, so bubbles close up and input keeps flowing
// while a result waits on the output, until the stages behind it are full. All
// planes reset to zero, which culls every item until the planes are written.
module aabb_frustum_cull
    import aafc_pkg::*;
#(
    parameter  int COORD_WIDTH = 16,
    localparam int S_TDATA_W   = ((6 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [0:0]            s_tuser,   // kind
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // inside_res, then zero padding
);

    plane_t                        plane         [PLANE_COUNT];
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic                          kind_reg;
    logic signed [COORD_WIDTH-1:0] lo_reg        [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] hi_reg        [AXIS_COUNT];
    logic                          prod_valid_reg;
    logic                          prod_valid_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          inside_reg;
    logic                          inside_next;
    logic [PLANE_COUNT-1:0]        behind;
    logic                          out_free;
    logic                          prod_free;
    logic                          in_free;
    logic                          in_load;
    logic                          prod_load;

    aafc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .plane     (plane)
    );

    // A stage may load when it is empty or its item moves on this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    assign prod_free = !prod_valid_reg || out_free;
    assign in_free   = !in_valid_reg || prod_free;
    assign in_load   = in_free && s_tvalid;
    assign prod_load = prod_free && in_valid_reg;
    assign s_tready  = in_free;

    // Stage valid flags.
    always_comb
    begin
        in_valid_next   = in_free ? s_tvalid : in_valid_reg;
        prod_valid_next = prod_free ? in_valid_reg : prod_valid_reg;
        out_valid_next  = out_free ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input register: unpack the six coordinates, min corner first.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            kind_reg <= s_tuser[0];
            for (int k = 0; k < AXIS_COUNT; k++)
            begin
                lo_reg[k] <= s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
                hi_reg[k] <= s_tdata[(k+AXIS_COUNT)*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    // One evaluator per plane, all working on the same item.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        aafc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_eval (
            .clk    (clk),
            .load   (prod_load),
            .kind   (kind_reg),
            .lo     (lo_reg),
            .hi     (hi_reg),
            .plane  (plane[p]),
            .behind (behind[p])
        );
    end

    // Result register: the item survives only if no plane rejects it.
    assign inside_next = ~(|behind);

    always_ff @(posedge clk)
    begin
        if (out_free && prod_valid_reg)
        begin
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, inside_reg};

endmodule

### rtl/aafc_checker.sv
// Port-level checks of the culling block, bound to its top level.
module aafc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // A free output means every stage can move, so input is never blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
    else $error("input blocked while output is free");

    // With no new item and a free output, the three stages drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s_acc && m_tready) ##1 (!s_acc && m_tready) ##1 (!s_acc && m_tready)
        |=> !m_tvalid)
    else $error("result appeared with no item in flight");

    // Padding bits of a result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("nonzero padding in result");

endmodule

bind aabb_frustum_cull aafc_checker u_aafc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/aabb_frustum_cull_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the frustum culling block with its own culling predictor.
module aabb_frustum_cull_tb;
    import aafc_pkg::*;

    localparam int COORD_W    = 16;
    localparam int S_DATA_W   = ((6 * COORD_W + 7) / 8) * 8;
    localparam int PIPE_DEPTH = 3;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES   = 6;

    // Indexes past the last plane; writes there must leave the planes alone.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

    // Plane styles used by the random phases.
    typedef enum int {STYLE_FRUSTUM, STYLE_RANDOM, STYLE_MIXED, STYLE_EXTREME} plane_style_t;

    localparam logic [CFG_ADDR_W-1:0] PLANE_INDEX [PLANE_COUNT] = '{
        REG_PLANE_RIGHT, REG_PLANE_LEFT, REG_PLANE_BOTTOM,
        REG_PLANE_TOP, REG_PLANE_FAR, REG_PLANE_NEAR
    };

    // One input item, fields named as on the bus.
    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_x;
    } cull_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // min_x, min_y, min_z, max_x, max_y, max_z
    logic [0:0]            s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // inside_res, then zero padding

    // Predictor copy of the planes and the inside flags still to come.
    plane_t plane_copy [PLANE_COUNT];
    logic   inside_q [$];

    int mismatches;
    int results_seen;
    int culled_seen;
    int boxes_sent;
    int points_sent;
    int plane_writes;
    int tx_gap_pct;
    int rx_stall_pct;
    int idle_cycles;

    aabb_frustum_cull #(
        .COORD_WIDTH (COORD_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Plane expression a*x + b*y + c*z + d*2^14, exact.
    function automatic longint plane_expr(plane_t p, longint x, longint y, longint z);
        return longint'($signed(p.a)) * x + longint'($signed(p.b)) * y +
               longint'($signed(p.c)) * z +
               longint'($signed(p.d)) * (longint'(1) << NORMAL_FRAC);
    endfunction

    // Expected inside flag: a point dies on any plane, a box only when all
    // eight corners lie on or behind one plane.
    function automatic logic predict_inside(cull_item_t it);
        longint lo [AXIS_COUNT];
        longint hi [AXIS_COUNT];
        logic   visible;
        logic   all_out;
        visible = 1'b1;
        lo[0] = $signed(it.min_x);
        lo[1] = $signed(it.min_y);
        lo[2] = $signed(it.min_z);
        hi[0] = $signed(it.max_x);
        hi[1] = $signed(it.max_y);
        hi[2] = $signed(it.max_z);
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            if (it.kind == KIND_POINT)
            begin
                if (plane_expr(plane_copy[i], lo[0], lo[1], lo[2]) <= 0)
                    visible = 1'b0;
            end
            else
            begin
                all_out = 1'b1;
                for (int c = 0; c < 8; c++)
                begin
                    if (plane_expr(plane_copy[i], c[0] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
                                   c[2] ? hi[2] : lo[2]) > 0)
                        all_out = 1'b0;
                end
                if (all_out)
                    visible = 1'b0;
            end
        end
        return visible;
    endfunction

    function automatic plane_t mk_plane(int a, int b, int c, int d);
        plane_t p;
        p.a = 16'(a);
        p.b = 16'(b);
        p.c = 16'(c);
        p.d = 16'(d);
        return p;
    endfunction

    function automatic cull_item_t mk_item(logic kind, int x0, int y0, int z0,
                                           int x1, int y1, int z1);
        cull_item_t it;
        it.kind  = kind;
        it.min_x = 16'(x0);
        it.min_y = 16'(y0);
        it.min_z = 16'(z0);
        it.max_x = 16'(x1);
        it.max_y = 16'(y1);
        it.max_z = 16'(z1);
        return it;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A coordinate near the origin within the span, or anywhere in range.
    function automatic logic [COORD_W-1:0] rand_coord(int span);
        if ($urandom_range(0, 9) == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Register write; the predictor drops indexes past the last plane.
    task automatic write_plane(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx < PLANE_COUNT)
            plane_copy[idx] = value;
        plane_writes++;
    endtask

    task automatic write_all_planes(plane_t p [PLANE_COUNT]);
        for (int i = 0; i < PLANE_COUNT; i++)
            write_plane(PLANE_INDEX[i], p[i]);
    endtask

    // Present one item, hold it until accepted, then maybe leave a gap.
    task automatic send_item(cull_item_t it);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.max_z, it.max_y, it.max_x, it.min_z, it.min_y, it.min_x};
        do
            @(posedge clk);
        while (!s_tready);
        inside_q.push_back(predict_inside(it));
        if (it.kind == KIND_POINT)
            points_sent++;
        else
            boxes_sent++;
        if ($urandom_range(0, 99) < tx_gap_pct)
        begin
            gap = pick_gap();
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every result is back and the pipe is empty.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (inside_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Planes at reset are all zero, so everything is culled.
    task automatic test_reset_planes();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_item(mk_item(KIND_POINT, 0, 0, 0, 0, 0, 0));
        send_item(mk_item(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        send_item(mk_item(KIND_BOX, -256, -256, -256, 256, 256, 256));
        send_item(mk_item(KIND_POINT, 32767, -32768, 1, 0, 0, 0));
        drain_results();
    endtask

    // Axis-aligned cube of half-size 10.0 around the origin.
    task automatic test_axis_cube();
        plane_t p [PLANE_COUNT];
        p[0] = mk_plane(-16384, 0, 0, 2560);
        p[1] = mk_plane(16384, 0, 0, 2560);
        p[2] = mk_plane(0, 16384, 0, 2560);
        p[3] = mk_plane(0, -16384, 0, 2560);
        p[4] = mk_plane(0, 0, -16384, 2560);
        p[5] = mk_plane(0, 0, 16384, 2560);
        write_all_planes(p);
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        send_item(mk_item(KIND_POINT, 0, 0, 0, 0, 0, 0));
        // A point exactly on a plane gives zero and is culled.
        send_item(mk_item(KIND_POINT, 2560, 0, 0, 0, 0, 0));
        send_item(mk_item(KIND_POINT, 2559, -2559, 2559, 0, 0, 0));
        // Max fields are ignored for points.
        send_item(mk_item(KIND_POINT, 0, 0, 0, 32767, 32767, 32767));
        send_item(mk_item(KIND_POINT, 9000, 0, 0, -100, -100, -100));
        send_item(mk_item(KIND_BOX, 3000, 0, 0, 4000, 10, 10));
        send_item(mk_item(KIND_BOX, -100, -100, -100, 3000, 100, 100));
        // Box touching the plane from outside is still culled.
        send_item(mk_item(KIND_BOX, 2560, 0, 0, 4000, 10, 10));
        // Inverted boxes use the same eight corners.
        send_item(mk_item(KIND_BOX, 3000, 100, 100, -100, -100, -100));
        send_item(mk_item(KIND_BOX, 4000, 0, 0, 3000, 10, 10));
        send_item(mk_item(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        send_item(mk_item(KIND_BOX, -32768, -32768, -32768, -32768, -32768, -32768));
        send_item(mk_item(KIND_POINT, 32767, 32767, 32767, 0, 0, 0));
        drain_results();
    endtask

    // Components at their extremes; the other planes pass everything.
    task automatic test_extreme_planes();
        plane_t p [PLANE_COUNT];
        p[0] = mk_plane(-32768, -32768, -32768, 32767);
        p[1] = mk_plane(32767, 32767, 32767, -32768);
        for (int i = 2; i < PLANE_COUNT; i++)
            p[i] = mk_plane(0, 0, 0, 1);
        write_all_planes(p);
        send_item(mk_item(KIND_POINT, -32768, -32768, -32768, 0, 0, 0));
        send_item(mk_item(KIND_POINT, 32767, 32767, 32767, 0, 0, 0));
        send_item(mk_item(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767));
        send_item(mk_item(KIND_BOX, 32767, 32767, 32767, -32768, -32768, -32768));
        send_item(mk_item(KIND_POINT, 1, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    // Writes past the last plane change nothing.
    task automatic test_unused_index();
        write_plane(REG_UNUSED_LO, {$urandom, $urandom});
        write_plane(REG_UNUSED_HI, '0);
        send_item(mk_item(KIND_POINT, -32768, -32768, -32768, 0, 0, 0));
        send_item(mk_item(KIND_BOX, 0, 0, 0, 32767, 32767, 32767));
        send_item(mk_item(KIND_POINT, 0, 0, 0, 0, 0, 0));
        drain_results();
    endtask

    function automatic int extreme_comp();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    // A plane facing into the origin along one axis, slightly tilted.
    function automatic plane_t frustum_plane(int i);
        int comp [AXIS_COUNT];
        for (int k = 0; k < AXIS_COUNT; k++)
            comp[k] = int'($urandom_range(0, 4000)) - 2000;
        comp[i / 2] = (i % 2 == 0) ? -16384 : 16384;
        return mk_plane(comp[0], comp[1], comp[2], $urandom_range(500, 6000));
    endfunction

    // Random phases with fresh planes each time.
    task automatic test_random_phases();
        plane_t       p [PLANE_COUNT];
        plane_style_t style;
        cull_item_t   it;
        int           span;
        int           extent;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            style = plane_style_t'(ph % 4);
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                case (style)
                    STYLE_FRUSTUM: p[i] = frustum_plane(i);
                    STYLE_RANDOM:  p[i] = {$urandom, $urandom};
                    STYLE_MIXED:   p[i] = $urandom_range(0, 1) ? frustum_plane(i) :
                                          mk_plane(0, 0, 0, int'($urandom_range(0, 600)) - 100);
                    default:       p[i] = mk_plane(extreme_comp(), extreme_comp(),
                                                   extreme_comp(), extreme_comp());
                endcase
            end
            write_all_planes(p);
            if ($urandom_range(0, 1))
                write_plane(REG_UNUSED_LO, {$urandom, $urandom});

            // The first phase runs without any idling on either side.
            if (ph == 0)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = $urandom_range(10, 50);
                rx_stall_pct = $urandom_range(10, 50);
            end
            span = (style == STYLE_FRUSTUM || style == STYLE_MIXED) ? 8000 : 32767;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.kind  = $urandom_range(0, 1) ? KIND_POINT : KIND_BOX;
                it.min_x = rand_coord(span);
                it.min_y = rand_coord(span);
                it.min_z = rand_coord(span);
                extent   = $urandom_range(0, span / 2);
                if ($urandom_range(0, 9) == 0)
                begin
                    it.max_x = it.min_x - 16'(extent);
                    it.max_y = rand_coord(span);
                    it.max_z = it.min_z - 16'($urandom_range(0, span / 2));
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    it.max_x = rand_coord(span);
                    it.max_y = rand_coord(span);
                    it.max_z = rand_coord(span);
                end
                else
                begin
                    it.max_x = it.min_x + 16'(extent);
                    it.max_y = it.min_y + 16'($urandom_range(0, span / 2));
                    it.max_z = it.min_z + 16'($urandom_range(0, span / 2));
                end
                send_item(it);
                // Hold off once mid-stream until every result is back.
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
            end
            drain_results();
        end
    endtask

    // Result side: random stalls, or none when the stall rate is zero.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < rx_stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare every accepted result with the oldest expected flag.
    always @(posedge clk)
    begin
        logic exp_inside;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[0] == 1'b0)
                culled_seen++;
            if (inside_q.size() == 0)
                report_mismatch($sformatf("result %0h with no item outstanding", m_tdata));
            else
            begin
                exp_inside = inside_q.pop_front();
                if (m_tdata[0] !== exp_inside)
                    report_mismatch($sformatf("inside_res %b, expected %b",
                                              m_tdata[0], exp_inside));
                if (m_tdata[M_TDATA_W-1:1] !== '0)
                    report_mismatch($sformatf("padding bits %0h not zero",
                                              m_tdata[M_TDATA_W-1:1]));
            end
        end
    end

    // Watchdog on cycles with no traffic at all.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no traffic for %0d cycles, %0d results outstanding",
                     idle_cycles, inside_q.size());
            $display("aabb_frustum_cull: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Test sequence.
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        mismatches   = 0;
        results_seen = 0;
        culled_seen  = 0;
        boxes_sent   = 0;
        points_sent  = 0;
        plane_writes = 0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        idle_cycles  = 0;
        for (int i = 0; i < PLANE_COUNT; i++)
            plane_copy[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_planes();
        test_axis_cube();
        test_extreme_planes();
        test_unused_index();
        test_random_phases();

        while (inside_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Sent %0d boxes and %0d points through %0d register writes.",
                 boxes_sent, points_sent, plane_writes);
        $display("Checked %0d results, %0d culled and %0d visible.",
                 results_seen, culled_seen, results_seen - culled_seen);
        if (mismatches == 0 && inside_q.size() == 0)
            $display("aabb_frustum_cull: match");
        else
            $display("aabb_frustum_cull: mismatch");
        $finish;
    end

endmodule

### aabb_frustum_cull.f
rtl/aafc_pkg.sv
rtl/aafc_cfg_regs.sv
rtl/aafc_plane_eval.sv
rtl/aabb_frustum_cull.sv
rtl/aafc_checker.sv
tb/aabb_frustum_cull_tb.sv
